// ----- sv/stbs_pkg.sv -----
// Shared types and constants for the sorted table bracket search block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package stbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 512;
   localparam int SIZE_W  = 10;
   localparam int INDEX_W = 9;
   localparam int KEY_W   = 32;
   localparam int POS_W   = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 10'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic [SIZE_W-1:0]         size_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [KEY_W-1:0]   key_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [SIZE_W-1:0]  bracket_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_FIRST,
      ST_LOAD_LAST,
      ST_SEARCH
   } state_type;

   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_START,
      RD_NEXT,
      RD_HOLD
   } rd_sel_type;

   typedef struct packed {
      logic       mem_write;
      logic       capture_query;
      logic       capture_first;
      logic       start_search;
      logic       step;
      logic       load_rsp;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ----- sv/stbs_if.sv -----
// Valid/ready channel interfaces for the request, response and register write words.
// Depends on stbs_pkg for field widths.
interface stbs_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   stbs_pkg::index_type  entry_index;
   stbs_pkg::key_type    entry_value;
   stbs_pkg::key_type    query_value;

   modport source (output valid, output func, output entry_index, output entry_value,
                   output query_value, input ready);
   modport sink   (input valid, input func, input entry_index, input entry_value,
                   input query_value, output ready);
endinterface

interface stbs_rsp_if;
   logic                  valid;
   logic                  ready;
   stbs_pkg::bracket_type bracket_index;
   logic                  descending;

   modport source (output valid, output bracket_index, output descending, input ready);
   modport sink   (input valid, input bracket_index, input descending, output ready);
endinterface

interface stbs_csr_if;
   logic                valid;
   logic                ready;
   stbs_pkg::size_type  table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ----- sv/stbs_ctrl.sv -----
// Controller state machine for the bracket search: sequences table writes, the two
// end-key reads and the bisection probes. Depends on stbs_pkg.
module stbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   input  stbs_pkg::dp_status_type status,
   output stbs_pkg::dp_cmd_type    cmd
);

   stbs_pkg::state_type state_ff;
   stbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (req_valid && (req_func == stbs_pkg::FUNC_QUERY)) begin
               state_in = stbs_pkg::ST_LOAD_FIRST;
            end
         end
         stbs_pkg::ST_LOAD_FIRST: begin
            state_in = stbs_pkg::ST_LOAD_LAST;
         end
         stbs_pkg::ST_LOAD_LAST: begin
            state_in = stbs_pkg::ST_SEARCH;
         end
         stbs_pkg::ST_SEARCH: begin
            if (status.search_done && !status.rsp_busy) begin
               state_in = stbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      cmd.mem_write     = 1'b0;
      cmd.capture_query = 1'b0;
      cmd.capture_first = 1'b0;
      cmd.start_search  = 1'b0;
      cmd.step          = 1'b0;
      cmd.load_rsp      = 1'b0;
      cmd.rd_sel        = stbs_pkg::RD_HOLD;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.rd_sel = stbs_pkg::RD_FIRST;
            if (req_valid && (req_func == stbs_pkg::FUNC_WRITE)) begin
               cmd.mem_write = 1'b1;
            end
            if (req_valid && (req_func == stbs_pkg::FUNC_QUERY)) begin
               cmd.capture_query = 1'b1;
            end
         end
         stbs_pkg::ST_LOAD_FIRST: begin
            cmd.capture_first = 1'b1;
            cmd.rd_sel        = stbs_pkg::RD_LAST;
         end
         stbs_pkg::ST_LOAD_LAST: begin
            cmd.start_search = 1'b1;
            cmd.rd_sel       = stbs_pkg::RD_START;
         end
         stbs_pkg::ST_SEARCH: begin
            if (!status.search_done) begin
               cmd.step   = 1'b1;
               cmd.rd_sel = stbs_pkg::RD_NEXT;
            end else if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == stbs_pkg::FUNC_QUERY))
         |=> (state_ff == stbs_pkg::ST_LOAD_FIRST))
      else $error("query accepted but search did not start");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != stbs_pkg::ST_IDLE) |-> (!cmd.mem_write && !req_ready))
      else $error("table write or request taken during a search");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stbs_pkg::ST_LOAD_FIRST) |=> (state_ff == stbs_pkg::ST_LOAD_LAST))
      else $error("end key reads out of sequence");

endmodule

// ----- sv/stbs_dp.sv -----
// Datapath for the bracket search: key memory, size register, bisection bounds and
// the response register. Depends on stbs_pkg and the channel interfaces.
module stbs_dp #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stbs_pkg::index_type     req_entry_index,
   input  stbs_pkg::key_type       req_entry_value,
   input  stbs_pkg::key_type       req_query_value,
   stbs_csr_if.sink                csr_ch,
   stbs_rsp_if.source              rsp_ch,
   input  stbs_pkg::dp_cmd_type    cmd,
   output stbs_pkg::dp_status_type status
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam stbs_pkg::size_type DEPTH_CAP =
      (TABLE_DEPTH > 1023) ? 10'd1023 : stbs_pkg::SIZE_W'(TABLE_DEPTH);

   stbs_pkg::key_type     key_mem [TABLE_DEPTH];
   stbs_pkg::key_type     rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  wr_en;
   stbs_pkg::size_type    rd_idx;

   stbs_pkg::size_type    size_ff;
   stbs_pkg::size_type    used_size;
   stbs_pkg::key_type     query_ff;
   stbs_pkg::key_type     first_ff;
   logic                  asc_ff;
   stbs_pkg::pos_type     lo_ff;
   stbs_pkg::pos_type     hi_ff;
   stbs_pkg::size_type    mid_ff;

   stbs_pkg::size_type    last_idx;
   stbs_pkg::size_type    start_mid;
   logic                  go_lo;
   stbs_pkg::pos_type     mid_pos;
   stbs_pkg::pos_type     lo_in;
   stbs_pkg::pos_type     hi_in;
   logic signed [stbs_pkg::POS_W:0] span;
   logic signed [stbs_pkg::POS_W:0] mid_sum;
   stbs_pkg::size_type    next_mid;

   logic                  rsp_valid_ff;
   stbs_pkg::bracket_type bracket_ff;
   logic                  desc_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= stbs_pkg::SIZE_RESET;
      end else if (csr_ch.valid) begin
         size_ff <= csr_ch.table_size;
      end
   end

   always_comb begin
      if (size_ff < stbs_pkg::SIZE_MIN) begin
         used_size = stbs_pkg::SIZE_MIN;
      end else if (size_ff > DEPTH_CAP) begin
         used_size = DEPTH_CAP;
      end else begin
         used_size = size_ff;
      end
   end

   assign last_idx  = used_size - 10'd1;
   assign start_mid = last_idx >> 1;

   assign go_lo   = ((query_ff > rd_data_ff) == asc_ff);
   assign mid_pos = $signed({1'b0, mid_ff});
   assign lo_in   = go_lo ? mid_pos : lo_ff;
   assign hi_in   = go_lo ? hi_ff : mid_pos;
   assign span    = {hi_in[stbs_pkg::POS_W-1], hi_in} - {lo_in[stbs_pkg::POS_W-1], lo_in};
   assign mid_sum = {lo_in[stbs_pkg::POS_W-1], lo_in} + {hi_in[stbs_pkg::POS_W-1], hi_in};
   assign next_mid = mid_sum[stbs_pkg::SIZE_W:1];

   assign status.search_done = (span == 12'sd1);
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ch.ready;

   always_comb begin
      case (cmd.rd_sel)
         stbs_pkg::RD_FIRST: rd_idx = '0;
         stbs_pkg::RD_LAST:  rd_idx = last_idx;
         stbs_pkg::RD_START: rd_idx = start_mid;
         stbs_pkg::RD_NEXT:  rd_idx = next_mid;
         default:            rd_idx = mid_ff;
      endcase
   end

   assign rd_addr = AW'(rd_idx);
   assign wr_addr = AW'(req_entry_index);
   assign wr_en   = cmd.mem_write && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= req_entry_value;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_query) begin
         query_ff <= req_query_value;
      end
      if (cmd.capture_first) begin
         first_ff <= rd_data_ff;
      end
      if (cmd.start_search) begin
         asc_ff <= (rd_data_ff > first_ff);
         lo_ff  <= -11'sd1;
         hi_ff  <= $signed({1'b0, used_size});
         mid_ff <= start_mid;
      end else if (cmd.step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= next_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         bracket_ff <= stbs_pkg::SIZE_W'(lo_in);
         desc_ff    <= !asc_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.bracket_index = bracket_ff;
   assign rsp_ch.descending    = desc_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ((lo_ff < mid_pos) && (mid_pos < hi_ff)))
      else $error("probe index outside the search bounds");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp_ch.ready))
      else $error("response word overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      cmd.start_search |=> ((lo_ff == -11'sd1) && (hi_ff > 11'sd1)))
      else $error("search started with wrong bounds");

endmodule

// ----- sv/sorted_table_bracket_search.sv -----
// Top level of the sorted table bracket search block.
// Depends on stbs_pkg, the channel interfaces, stbs_ctrl and stbs_dp.
//
// The block holds a table of signed Q16.16 keys, written one word at a time, and
// answers bracket queries by bisection over the first table_size entries, clamped to
// at least 2 and at most TABLE_DEPTH, with the direction taken from the end keys. A
// table write gives no response. A query first reads the two end keys, then makes one
// probe per cycle, set by the single read port of the key memory, and loads its
// response word once the bounds meet and the response register is free. The next
// request is taken in the cycle after the response word is loaded. The response sits
// in an output register, so a new request is taken while it waits. Entries never
// written read as undefined; there is no clearing pass after reset.
module sorted_table_bracket_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   stbs_req_if.sink    req_ch,
   stbs_rsp_if.source  rsp_ch,
   stbs_csr_if.sink    csr_ch
);

   stbs_pkg::dp_cmd_type    cmd;
   stbs_pkg::dp_status_type status;
   logic                    req_ready;

   assign req_ch.ready = req_ready;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_entry_index (req_ch.entry_index),
      .req_entry_value (req_ch.entry_value),
      .req_query_value (req_ch.query_value),
      .csr_ch          (csr_ch),
      .rsp_ch          (rsp_ch),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for sorted_table_bracket_search: loads rising, falling, flat and scrambled key
// tables, sends bracket queries and checks each response word against a local bisection.
// Depends on stbs_pkg, the channel interfaces of stbs_if.sv and the block's RTL.
module tb_top;

   localparam int DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 850;
   localparam int REPORT_LIMIT = 10;
   localparam stbs_pkg::key_type KEY_MIN = 32'sh8000_0000;
   localparam stbs_pkg::key_type KEY_MAX = 32'sh7fff_ffff;

   typedef enum int {SHAPE_RISE, SHAPE_FALL, SHAPE_FLAT, SHAPE_SCRAMBLE} shape_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN} ready_mode_type;

   typedef struct {
      logic                an_func;
      stbs_pkg::index_type entry_index;
      stbs_pkg::key_type   entry_value;
      stbs_pkg::key_type   query_value;
   } req_word_type;

   typedef struct {
      stbs_pkg::bracket_type bracket_index;
      logic                  descending;
   } bracket_word_type;

   logic clock;
   logic reset;

   stbs_req_if req_ch();
   stbs_rsp_if rsp_ch();
   stbs_csr_if csr_ch();

   sorted_table_bracket_search DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   req_word_type     pending_words[$];
   bracket_word_type bracket_q[$];

   stbs_pkg::key_type  key_shadow[DEPTH];
   stbs_pkg::size_type size_shadow = stbs_pkg::SIZE_RESET;
   stbs_pkg::key_type  plan_keys[DEPTH];

   int items_planned = 0;
   int writes_accepted = 0;
   int queries_accepted = 0;
   int results_checked = 0;
   int fail_count = 0;
   int size_writes = 0;

   req_word_type     next_word;
   bracket_word_type expected_word;
   int               burst_left;
   int               gap_left;
   ready_mode_type   ready_mode;
   int               mode_left;
   int               ready_phase;
   int               hold_left;
   int               holds_done;
   logic             holding;

   function automatic int used_entries(stbs_pkg::size_type s);
      if (s < stbs_pkg::SIZE_MIN) begin
         return int'(stbs_pkg::SIZE_MIN);
      end
      if (s > DEPTH) begin
         return DEPTH;
      end
      return int'(s);
   endfunction

   function automatic bracket_word_type predict_bracket(stbs_pkg::key_type x);
      bracket_word_type w;
      int n;
      int lo;
      int hi;
      int mid;
      logic rising;
      n = used_entries(size_shadow);
      rising = key_shadow[n-1] > key_shadow[0];
      lo = -1;
      hi = n;
      while (hi - lo != 1) begin
         mid = (hi + lo) >>> 1;
         if ((x > key_shadow[mid]) == rising) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      w.bracket_index = lo[stbs_pkg::SIZE_W-1:0];
      w.descending = !rising;
      return w;
   endfunction

   function automatic stbs_pkg::key_type pick_query(int n);
      stbs_pkg::key_type k;
      k = plan_keys[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return k;
         4: return k + 1;
         5: return k - 1;
         6: return ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
         7, 8: return k + stbs_pkg::key_type'($urandom_range(0, 131072)) - 65536;
         default: return stbs_pkg::key_type'($urandom);
      endcase
   endfunction

   task automatic push_write(int idx, stbs_pkg::key_type value);
      req_word_type w;
      w.an_func = stbs_pkg::FUNC_WRITE;
      w.entry_index = idx[stbs_pkg::INDEX_W-1:0];
      w.entry_value = value;
      w.query_value = stbs_pkg::key_type'($urandom);
      pending_words.push_back(w);
      plan_keys[idx] = value;
      items_planned++;
   endtask

   task automatic push_query(stbs_pkg::key_type value);
      req_word_type w;
      w.an_func = stbs_pkg::FUNC_QUERY;
      w.entry_index = stbs_pkg::index_type'($urandom);
      w.entry_value = stbs_pkg::key_type'($urandom);
      w.query_value = value;
      pending_words.push_back(w);
      items_planned++;
   endtask

   task automatic load_table(int n, shape_type shape);
      stbs_pkg::key_type vals[DEPTH];
      longint lo_b;
      longint hi_b;
      longint v;
      longint max_step;
      int i;
      lo_b = longint'(stbs_pkg::key_type'($urandom));
      hi_b = longint'(stbs_pkg::key_type'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         lo_b = KEY_MIN;
         hi_b = KEY_MAX;
      end
      if (lo_b > hi_b) begin
         v = lo_b;
         lo_b = hi_b;
         hi_b = v;
      end
      max_step = (hi_b - lo_b) / n;
      v = lo_b;
      for (i = 0; i < n; i++) begin
         vals[i] = v[31:0];
         if ($urandom_range(0, 4) != 0) begin
            v = v + longint'($urandom_range(0, int'(max_step)));
         end
         if (v > hi_b) begin
            v = hi_b;
         end
      end
      for (i = 0; i < n; i++) begin
         case (shape)
            SHAPE_RISE: push_write(i, vals[i]);
            SHAPE_FALL: push_write(i, vals[n-1-i]);
            SHAPE_FLAT: push_write(i, (i == 0 || i == n - 1) ? vals[0] :
                                      stbs_pkg::key_type'($urandom));
            default: push_write(i, stbs_pkg::key_type'($urandom));
         endcase
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_ch.valid || bracket_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_size(stbs_pkg::size_type value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.table_size <= value;
      do @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      size_shadow = value;
      size_writes++;
   endtask

   initial begin
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.func = stbs_pkg::FUNC_WRITE;
      req_ch.entry_index = '0;
      req_ch.entry_value = '0;
      req_ch.query_value = '0;
      rsp_ch.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.func == stbs_pkg::FUNC_WRITE) begin
               key_shadow[req_ch.entry_index] = req_ch.entry_value;
               writes_accepted++;
            end else begin
               bracket_q.push_back(predict_bracket(req_ch.query_value));
               queries_accepted <= queries_accepted + 1;
            end
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (burst_left > 0 && pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.func <= next_word.an_func;
               req_ch.entry_index <= next_word.entry_index;
               req_ch.entry_value <= next_word.entry_value;
               req_ch.query_value <= next_word.query_value;
               burst_left--;
            end else begin
               req_ch.valid <= 1'b0;
               if (burst_left == 0 && gap_left > 0) begin
                  gap_left--;
               end
            end
         end
      end
   end

   // A long receiver hold-off, twice, so the response register fills and the request
   // channel backs up while queries keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         holds_done = 0;
         holding <= 1'b0;
      end else begin
         if (hold_left > 0) begin
            hold_left--;
         end else if ((holds_done == 0 && queries_accepted >= 30) ||
                      (holds_done == 1 && queries_accepted >= 150)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         holding <= (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         mode_left = 0;
         ready_phase = 0;
         ready_mode = READY_ALWAYS;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (bracket_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("Unexpected response word: bracket %0d descending %0b",
                           rsp_ch.bracket_index, rsp_ch.descending);
               end
            end else begin
               expected_word = bracket_q.pop_front();
               results_checked++;
               if (rsp_ch.bracket_index !== expected_word.bracket_index ||
                   rsp_ch.descending !== expected_word.descending) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("Mismatch on response %0d: expected %0d/%0b, got %0d/%0b",
                              results_checked, expected_word.bracket_index,
                              expected_word.descending, rsp_ch.bracket_index,
                              rsp_ch.descending);
                  end
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         ready_phase = (ready_phase + 1) % 5;
         case (ready_mode)
            READY_ALWAYS: rsp_ch.ready <= !holding;
            READY_COIN: rsp_ch.ready <= !holding && ($urandom_range(0, 1) == 0);
            default: rsp_ch.ready <= !holding && (ready_phase < 2);
         endcase
      end
   end

   initial begin
      int size;
      int n;
      int drain_wait;
      shape_type shape;
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.table_size = stbs_pkg::SIZE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_table_size(stbs_pkg::SIZE_MIN);
      push_write(0, KEY_MIN);
      push_write(1, KEY_MAX);
      push_query(KEY_MIN);
      push_query(KEY_MAX);
      push_query(0);
      push_query(-1);
      push_write(0, 32'sh0001_0000);
      push_write(1, 32'sh0001_0000);
      push_query(32'sh0001_0000);
      push_query(0);
      push_query(KEY_MAX);
      push_write(0, KEY_MAX);
      push_write(1, KEY_MIN);
      push_query(KEY_MAX);
      push_query(KEY_MIN);
      push_query(0);
      write_table_size(stbs_pkg::size_type'(0));
      push_query(-5);
      write_table_size(stbs_pkg::size_type'(1));
      push_query(KEY_MAX);

      items_planned = 0;
      write_table_size(stbs_pkg::SIZE_RESET);
      load_table(DEPTH, SHAPE_RISE);
      repeat (80) push_query(pick_query(DEPTH));
      write_table_size(stbs_pkg::size_type'(1023));
      repeat (20) begin
         if ($urandom_range(0, 9) == 0) begin
            push_write($urandom_range(0, DEPTH - 1), stbs_pkg::key_type'($urandom));
         end else begin
            push_query(pick_query(DEPTH));
         end
      end

      while (items_planned < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: size = $urandom_range(0, 1);
            1: size = $urandom_range(100, 511);
            2: size = $urandom_range(513, 1023);
            default: size = $urandom_range(2, 40);
         endcase
         n = used_entries(stbs_pkg::size_type'(size));
         write_table_size(stbs_pkg::size_type'(size));
         if (n <= 64) begin
            case ($urandom_range(0, 7))
               0, 1, 2: shape = SHAPE_RISE;
               3, 4, 5: shape = SHAPE_FALL;
               6: shape = SHAPE_FLAT;
               default: shape = SHAPE_SCRAMBLE;
            endcase
            load_table(n, shape);
         end
         repeat ($urandom_range(10, 40)) begin
            if ($urandom_range(0, 9) == 0) begin
               push_write($urandom_range(0, DEPTH - 1), stbs_pkg::key_type'($urandom));
            end else begin
               push_query(pick_query(n));
            end
         end
      end

      drain_wait = 0;
      do begin
         @(negedge clock);
         drain_wait++;
      end while ((pending_words.size() != 0 || req_ch.valid || bracket_q.size() != 0) &&
                 drain_wait < 20000);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count = fail_count + bracket_q.size() + pending_words.size();

      $display("Run covered %0d table writes and %0d bracket queries over %0d size settings.",
               writes_accepted, queries_accepted, size_writes);
      $display("Checked %0d response words, %0d left outstanding.",
               results_checked, bracket_q.size());
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: the block stopped moving words.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
